FILE: rtl/udrla_pkg.sv
`timescale 1ns / 1ps

package udrla_pkg;

   localparam int COUNT_WIDTH   = 16;
   localparam int FRACTION_BITS = 16;
   localparam int QUOT_WIDTH    = COUNT_WIDTH + FRACTION_BITS;
   localparam int ITER_WIDTH    = $clog2(QUOT_WIDTH + 1);

   typedef logic [COUNT_WIDTH-1:0] cnt_type;
   typedef logic [QUOT_WIDTH-1:0]  quot_type;

   typedef enum logic [1:0] {
      SLOPE_NONE = 2'd0,
      SLOPE_UP   = 2'd1,
      SLOPE_DOWN = 2'd2,
      SLOPE_FLAT = 2'd3
   } slope_type;

   // Closed-out totals of one sequence; run counts are already at least one.
   typedef struct packed {
      cnt_type up_steps;
      cnt_type up_runs;
      cnt_type down_steps;
      cnt_type down_runs;
      cnt_type samples;
   } totals_type;

   function automatic cnt_type sat_add(cnt_type a, cnt_type b);
      logic [COUNT_WIDTH:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[COUNT_WIDTH] ? '1 : s[COUNT_WIDTH-1:0];
   endfunction

   function automatic logic [31:0] sat32(quot_type q);
      logic [63:0] w;
      w = 64'(q);
      return (w > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : w[31:0];
   endfunction

   function automatic logic [15:0] sat16(cnt_type c);
      logic [63:0] w;
      w = 64'(c);
      return (w > 64'h0000_0000_0000_FFFF) ? 16'hFFFF : w[15:0];
   endfunction

endpackage

FILE: rtl/udrla_if.sv
`timescale 1ns / 1ps

interface udrla_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] sample;
   logic               last;

   modport source (output valid, output sample, output last, input ready);
   modport sink   (input valid, input sample, input last, output ready);
endinterface

interface udrla_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] value_count;
   logic [31:0] up_average;
   logic [31:0] down_average;

   modport source (output valid, output value_count, output up_average,
                   output down_average, input ready);
   modport sink   (input valid, input value_count, input up_average,
                   input down_average, output ready);
endinterface

FILE: rtl/udrla_tracker.sv
`timescale 1ns / 1ps

module udrla_tracker
   import udrla_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic signed [31:0] sample,
   input  logic               last,
   output totals_type         totals
);

   logic signed [31:0] prev_ff, prev_in;
   logic               have_prev_ff, have_prev_in;
   slope_type          slope_ff, slope_in;
   slope_type          before_ff, before_in;
   cnt_type            flat_ff, flat_in;
   cnt_type            rise_steps_ff, rise_steps_in;
   cnt_type            fall_steps_ff, fall_steps_in;
   cnt_type            rise_runs_ff, rise_runs_in;
   cnt_type            fall_runs_ff, fall_runs_in;
   cnt_type            count_ff, count_in;

   // step update for this sample
   slope_type n_slope, n_before;
   cnt_type   n_flat, n_rs, n_fs, n_rr, n_fr, n_cnt;
   // closed totals on the last sample
   cnt_type   c_rs, c_fs, c_rr, c_fr;

   always_comb begin
      n_slope  = slope_ff;
      n_before = before_ff;
      n_flat   = flat_ff;
      n_rs     = rise_steps_ff;
      n_fs     = fall_steps_ff;
      n_rr     = rise_runs_ff;
      n_fr     = fall_runs_ff;
      if (have_prev_ff) begin
         if (prev_ff < sample) begin
            if (slope_ff == SLOPE_FLAT) begin
               if (before_ff == SLOPE_DOWN) begin
                  n_fs = sat_add(n_fs, flat_ff);
                  n_fr = sat_add(n_fr, cnt_type'(1));
               end else begin
                  n_rs = sat_add(n_rs, flat_ff);
               end
            end else if (slope_ff == SLOPE_DOWN) begin
               n_fr = sat_add(n_fr, cnt_type'(1));
            end
            n_rs     = sat_add(n_rs, cnt_type'(1));
            n_slope  = SLOPE_UP;
            n_before = SLOPE_UP;
            n_flat   = '0;
         end else if (prev_ff > sample) begin
            if (slope_ff == SLOPE_FLAT) begin
               if (before_ff == SLOPE_UP) begin
                  n_rs = sat_add(n_rs, flat_ff);
                  n_rr = sat_add(n_rr, cnt_type'(1));
               end else begin
                  n_fs = sat_add(n_fs, flat_ff);
               end
            end else if (slope_ff == SLOPE_UP) begin
               n_rr = sat_add(n_rr, cnt_type'(1));
            end
            n_fs     = sat_add(n_fs, cnt_type'(1));
            n_slope  = SLOPE_DOWN;
            n_before = SLOPE_DOWN;
            n_flat   = '0;
         end else begin
            n_flat  = sat_add(flat_ff, cnt_type'(1));
            n_slope = SLOPE_FLAT;
         end
      end
      n_cnt = sat_add(count_ff, cnt_type'(1));

      // close the open run
      c_rs = n_rs;
      c_fs = n_fs;
      c_rr = n_rr;
      c_fr = n_fr;
      case (n_slope)
         SLOPE_UP:   c_rr = sat_add(n_rr, cnt_type'(1));
         SLOPE_DOWN: c_fr = sat_add(n_fr, cnt_type'(1));
         SLOPE_FLAT: begin
            if (n_before == SLOPE_UP) begin
               c_rs = sat_add(n_rs, n_flat);
               c_rr = sat_add(n_rr, cnt_type'(1));
            end else if (n_before == SLOPE_DOWN) begin
               c_fs = sat_add(n_fs, n_flat);
               c_fr = sat_add(n_fr, cnt_type'(1));
            end
         end
         default: ;
      endcase

      totals.up_steps   = c_rs;
      totals.up_runs    = (c_rr == '0) ? cnt_type'(1) : c_rr;
      totals.down_steps = c_fs;
      totals.down_runs  = (c_fr == '0) ? cnt_type'(1) : c_fr;
      totals.samples    = n_cnt;
   end

   always_comb begin
      prev_in       = prev_ff;
      have_prev_in  = have_prev_ff;
      slope_in      = slope_ff;
      before_in     = before_ff;
      flat_in       = flat_ff;
      rise_steps_in = rise_steps_ff;
      fall_steps_in = fall_steps_ff;
      rise_runs_in  = rise_runs_ff;
      fall_runs_in  = fall_runs_ff;
      count_in      = count_ff;
      if (accept) begin
         if (last) begin
            // clear for the next sequence
            prev_in       = '0;
            have_prev_in  = 1'b0;
            slope_in      = SLOPE_NONE;
            before_in     = SLOPE_NONE;
            flat_in       = '0;
            rise_steps_in = '0;
            fall_steps_in = '0;
            rise_runs_in  = '0;
            fall_runs_in  = '0;
            count_in      = '0;
         end else begin
            prev_in       = sample;
            have_prev_in  = 1'b1;
            slope_in      = n_slope;
            before_in     = n_before;
            flat_in       = n_flat;
            rise_steps_in = n_rs;
            fall_steps_in = n_fs;
            rise_runs_in  = n_rr;
            fall_runs_in  = n_fr;
            count_in      = n_cnt;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff       <= '0;
         have_prev_ff  <= 1'b0;
         slope_ff      <= SLOPE_NONE;
         before_ff     <= SLOPE_NONE;
         flat_ff       <= '0;
         rise_steps_ff <= '0;
         fall_steps_ff <= '0;
         rise_runs_ff  <= '0;
         fall_runs_ff  <= '0;
         count_ff      <= '0;
      end else begin
         prev_ff       <= prev_in;
         have_prev_ff  <= have_prev_in;
         slope_ff      <= slope_in;
         before_ff     <= before_in;
         flat_ff       <= flat_in;
         rise_steps_ff <= rise_steps_in;
         fall_steps_ff <= fall_steps_in;
         rise_runs_ff  <= rise_runs_in;
         fall_runs_ff  <= fall_runs_in;
         count_ff      <= count_in;
      end
   end

endmodule

FILE: rtl/udrla_divider.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
module udrla_divider
   import udrla_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  cnt_type  steps,
   input  cnt_type  runs,
   output logic     done,
   output quot_type quotient
);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [ITER_WIDTH-1:0] iter_ff, iter_in;
   quot_type              shift_ff, shift_in;
   cnt_type               rem_ff, rem_in;
   cnt_type               divisor_ff, divisor_in;

   logic [COUNT_WIDTH:0] rem_shift;
   logic [COUNT_WIDTH:0] diff;

   always_comb begin
      rem_shift  = {rem_ff, shift_ff[QUOT_WIDTH-1]};
      diff       = rem_shift - {1'b0, divisor_ff};
      busy_in    = busy_ff;
      done_in    = 1'b0;
      iter_in    = iter_ff;
      shift_in   = shift_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      if (start) begin
         busy_in    = 1'b1;
         iter_in    = ITER_WIDTH'(QUOT_WIDTH);
         shift_in   = {steps, {FRACTION_BITS{1'b0}}};
         rem_in     = '0;
         divisor_in = runs;
      end else if (busy_ff) begin
         if (!diff[COUNT_WIDTH]) begin
            rem_in   = diff[COUNT_WIDTH-1:0];
            shift_in = {shift_ff[QUOT_WIDTH-2:0], 1'b1};
         end else begin
            rem_in   = rem_shift[COUNT_WIDTH-1:0];
            shift_in = {shift_ff[QUOT_WIDTH-2:0], 1'b0};
         end
         iter_in = iter_ff - ITER_WIDTH'(1);
         if (iter_ff == ITER_WIDTH'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         iter_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         iter_ff <= iter_in;
      end
      shift_ff   <= shift_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign done     = done_ff;
   assign quotient = shift_ff;

endmodule

FILE: rtl/up_down_run_length_averager.sv
`timescale 1ns / 1ps
//  channel  | direction | handshake         | word
//  req_chan | in        | valid/ready       | sample (s32), last
//  rsp_chan | out       | valid/ready       | value_count, up_average, down_average
//
//  A sample that is not the last is taken without a stall; samples stream back to back.
//  The last sample holds ready low while the shared restoring divider runs
//  twice, up average first, then down average, yielding one quotient bit a cycle.
//  Synchronous active-high reset clears all counters and drops rsp valid.
//  If the output register still holds an untaken word when the divisions end,
//  the finish step waits and ready stays low until that word is taken.

module up_down_run_length_averager
   import udrla_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   udrla_req_if.sink   req_chan,
   udrla_rsp_if.source rsp_chan
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV_UP,
      ST_DIV_DOWN,
      ST_FINISH
   } state_type;

   state_type   state_ff;
   logic        rsp_valid_ff;
   logic [15:0] count_out_ff;
   logic [31:0] up_out_ff;
   logic [31:0] down_out_ff;
   logic [15:0] count_hold_ff;
   logic [31:0] up_hold_ff;
   cnt_type     down_steps_ff;
   cnt_type     down_runs_ff;

   logic       accept;
   logic       load_rsp;
   totals_type totals;
   logic       div_start;
   cnt_type    div_steps;
   cnt_type    div_runs;
   logic       div_done;
   quot_type   div_quot;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;

   // load the output register from the finish step once it is free
   assign load_rsp = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_chan.ready);

   udrla_tracker u_tracker (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .sample (req_chan.sample),
      .last   (req_chan.last),
      .totals (totals)
   );

   // Start up division on the last word, down division when up finishes.
   always_comb begin
      div_start = 1'b0;
      div_steps = totals.up_steps;
      div_runs  = totals.up_runs;
      if (state_ff == ST_IDLE) begin
         div_start = accept && req_chan.last;
      end else if (state_ff == ST_DIV_UP) begin
         div_start = div_done;
         div_steps = down_steps_ff;
         div_runs  = down_runs_ff;
      end
   end

   udrla_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .steps    (div_steps),
      .runs     (div_runs),
      .done     (div_done),
      .quotient (div_quot)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // raise valid on a load, drop it once the word is taken
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept && req_chan.last) begin
                  down_steps_ff <= totals.down_steps;
                  down_runs_ff  <= totals.down_runs;
                  count_hold_ff <= sat16(totals.samples);
                  state_ff      <= ST_DIV_UP;
               end
            end
            ST_DIV_UP: begin
               if (div_done) begin
                  up_hold_ff <= sat32(div_quot);
                  state_ff   <= ST_DIV_DOWN;
               end
            end
            ST_DIV_DOWN: begin
               if (div_done) begin
                  down_out_ff <= sat32(div_quot);
                  state_ff    <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               // wait for a free output register, then load it
               if (load_rsp) begin
                  count_out_ff <= count_hold_ff;
                  up_out_ff    <= up_hold_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // down result is held separately until the output register frees up
   logic [31:0] down_word_ff;

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         down_word_ff <= down_out_ff;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.value_count  = count_out_ff;
   assign rsp_chan.up_average   = up_out_ff;
   assign rsp_chan.down_average = down_word_ff;

endmodule

FILE: rtl/udrla_checker.sv
`timescale 1ns / 1ps

module udrla_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_last,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_value_count,
   input logic [31:0] rsp_up_average,
   input logic [31:0] rsp_down_average
);

   // hold a stalled result word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp valid dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         $stable(rsp_value_count) && $stable(rsp_up_average) && $stable(rsp_down_average))
      else $error("rsp word changed while stalled");

   // inner samples stream without a bubble
   a_stream: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !req_last |=> req_ready)
      else $error("ready dropped after an inner sample");

   // the last sample starts the divisions
   a_last_stall: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_last |=> !req_ready)
      else $error("ready stayed high after the last sample");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid set out of reset");

endmodule

bind up_down_run_length_averager udrla_checker u_udrla_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_chan.valid),
   .req_ready        (req_chan.ready),
   .req_last         (req_chan.last),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_value_count  (rsp_chan.value_count),
   .rsp_up_average   (rsp_chan.up_average),
   .rsp_down_average (rsp_chan.down_average)
);

FILE: sim/up_down_run_length_averager_tb.sv
`timescale 1ns / 1ps

module up_down_run_length_averager_tb;
   import udrla_pkg::*;

   // One closed-out sequence as the result channel should carry it.
   typedef struct {
      logic [15:0] value_count;
      logic [31:0] up_average;
      logic [31:0] down_average;
   } run_summary_type;

   // How the random part walks through sample values.
   typedef enum int {
      WALK_SMALL,  // neighbors differ by -2..2, so flat steps are frequent
      WALK_FULL,   // every sample drawn over the whole 32-bit range
      WALK_EDGES   // samples taken from the signed extremes, zero and minus one
   } walk_kind_type;

   localparam logic [63:0] COUNT_CEILING = (64'd1 << COUNT_WIDTH) - 64'd1;
   localparam cnt_type     ONE_STEP      = cnt_type'(1);
   localparam int          SETTLE_CYCLES = 2 * (COUNT_WIDTH + FRACTION_BITS) + 16;
   localparam int          HOLD_CYCLES   = 400;

   logic clock;
   logic reset;

   udrla_req_if req_chan ();
   udrla_rsp_if rsp_chan ();

   up_down_run_length_averager u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Summaries still owed by the block, oldest first.
   run_summary_type expected_summaries[$];
   run_summary_type oldest_summary;
   int              mismatch_count = 0;

   // Idle controls shared by the sender, the receiver and the tests.
   bit send_gaps_on = 1'b1;
   bit take_gaps_on = 1'b1;
   int hold_request = 0;

   // Words of the next sequence, staged by a test and sent as one run.
   logic signed [31:0] seq_words[$];

   // Run tracker: our own copy of the slope and counter state.
   logic signed [31:0] level_prev;
   bit                 level_valid;
   slope_type          trend_now;
   slope_type          trend_before_flat;
   cnt_type            flat_count;
   cnt_type            up_steps;
   cnt_type            down_steps;
   cnt_type            up_runs;
   cnt_type            down_runs;
   cnt_type            seen_count;

   //--------------------------------------------------------------------------
   // Clock: 2 ns period.
   //--------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   //--------------------------------------------------------------------------
   // Hard stop in case the block hangs.
   //--------------------------------------------------------------------------
   initial begin
      #2_000_000;
      $display("simulation failed");
      $finish;
   end

   //--------------------------------------------------------------------------
   // Run tracker
   //--------------------------------------------------------------------------

   // Add and clamp at the top of the counter range.
   function automatic cnt_type cap_add(cnt_type a, cnt_type b);
      logic [63:0] total;
      total = 64'(a) + 64'(b);
      return (total > COUNT_CEILING) ? cnt_type'(COUNT_CEILING) : cnt_type'(total);
   endfunction

   // Mean run length in unsigned fixed point; a zero run count counts as one.
   function automatic logic [31:0] fixed_mean(cnt_type steps, cnt_type runs);
      logic [63:0] divisor;
      logic [63:0] quotient;
      divisor  = (runs == '0) ? 64'd1 : 64'(runs);
      quotient = (64'(steps) << FRACTION_BITS) / divisor;
      return (quotient > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : quotient[31:0];
   endfunction

   function automatic void clear_runs();
      level_prev        = '0;
      level_valid       = 1'b0;
      trend_now         = SLOPE_NONE;
      trend_before_flat = SLOPE_NONE;
      flat_count        = '0;
      up_steps          = '0;
      down_steps        = '0;
      up_runs           = '0;
      down_runs         = '0;
      seen_count        = '0;
   endfunction

   // Fold one accepted word into the run state; return 1 with the summary
   // when the word closes the sequence.
   function automatic bit fold_sample(input logic signed [31:0] word_sample,
                                      input bit word_last,
                                      output run_summary_type summary);
      logic [63:0] count_wide;
      summary = '{default: '0};
      if (level_valid) begin
         if (word_sample > level_prev) begin
            // Pending flat steps join the run they follow; leading ones join
            // this rising run.
            if (trend_now == SLOPE_FLAT) begin
               if (trend_before_flat == SLOPE_DOWN) begin
                  down_steps = cap_add(down_steps, flat_count);
                  down_runs  = cap_add(down_runs, ONE_STEP);
               end else begin
                  up_steps = cap_add(up_steps, flat_count);
               end
            end else if (trend_now == SLOPE_DOWN) begin
               down_runs = cap_add(down_runs, ONE_STEP);
            end
            up_steps          = cap_add(up_steps, ONE_STEP);
            trend_now         = SLOPE_UP;
            trend_before_flat = SLOPE_UP;
            flat_count        = '0;
         end else if (word_sample < level_prev) begin
            if (trend_now == SLOPE_FLAT) begin
               if (trend_before_flat == SLOPE_UP) begin
                  up_steps = cap_add(up_steps, flat_count);
                  up_runs  = cap_add(up_runs, ONE_STEP);
               end else begin
                  down_steps = cap_add(down_steps, flat_count);
               end
            end else if (trend_now == SLOPE_UP) begin
               up_runs = cap_add(up_runs, ONE_STEP);
            end
            down_steps        = cap_add(down_steps, ONE_STEP);
            trend_now         = SLOPE_DOWN;
            trend_before_flat = SLOPE_DOWN;
            flat_count        = '0;
         end else begin
            flat_count = cap_add(flat_count, ONE_STEP);
            trend_now  = SLOPE_FLAT;
         end
      end
      level_prev  = word_sample;
      level_valid = 1'b1;
      seen_count  = cap_add(seen_count, ONE_STEP);

      if (!word_last) begin
         return 1'b0;
      end

      // Close whatever run is still open; trailing flats join the run before.
      case (trend_now)
         SLOPE_UP: begin
            up_runs = cap_add(up_runs, ONE_STEP);
         end
         SLOPE_DOWN: begin
            down_runs = cap_add(down_runs, ONE_STEP);
         end
         SLOPE_FLAT: begin
            if (trend_before_flat == SLOPE_UP) begin
               up_steps = cap_add(up_steps, flat_count);
               up_runs  = cap_add(up_runs, ONE_STEP);
            end else if (trend_before_flat == SLOPE_DOWN) begin
               down_steps = cap_add(down_steps, flat_count);
               down_runs  = cap_add(down_runs, ONE_STEP);
            end
         end
         default: begin
         end
      endcase

      count_wide           = 64'(seen_count);
      summary.value_count  = (count_wide > 64'h0000_0000_0000_FFFF) ? 16'hFFFF
                                                                    : count_wide[15:0];
      summary.up_average   = fixed_mean(up_steps, up_runs);
      summary.down_average = fixed_mean(down_steps, down_runs);
      clear_runs();
      return 1'b1;
   endfunction

   //--------------------------------------------------------------------------
   // Sender: offer one word, wait for the handshake, then predict.
   // Valid stays high after acceptance so back-to-back words need no
   // lower/raise in the same step; a gap drops it first.
   //--------------------------------------------------------------------------
   task automatic send_word(input logic signed [31:0] word_sample, input bit word_last);
      int              gap;
      run_summary_type summary;
      gap = send_gaps_on ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid  <= 1'b1;
      req_chan.sample <= word_sample;
      req_chan.last   <= word_last;
      // Ready is read before this edge's updates land, so it is the value
      // the block presented for the handshake.
      do @(posedge clock); while (!req_chan.ready);
      if (fold_sample(word_sample, word_last, summary)) begin
         expected_summaries.push_back(summary);
      end
   endtask

   // Send the staged words as one sequence; flag the final one as last.
   task automatic send_queued();
      int n;
      n = seq_words.size();
      for (int i = 0; i < n; i++) begin
         send_word(seq_words[i], i == n - 1);
      end
      seq_words.delete();
   endtask

   //--------------------------------------------------------------------------
   // Receiver: one ready assignment per edge.
   // A hold request drops ready for that many cycles; otherwise draw a
   // random stall after each accepted result.
   //--------------------------------------------------------------------------
   initial begin
      int hold_left;
      int stall_left;
      bit took;
      hold_left  = 0;
      stall_left = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         took = rsp_chan.valid && rsp_chan.ready && !reset;
         if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else if (took) begin
            stall_left = take_gaps_on ? $urandom_range(0, 6) : 0;
            rsp_chan.ready <= (stall_left == 0);
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_chan.ready <= (stall_left == 0);
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   //--------------------------------------------------------------------------
   // Result checker: compare each accepted result with the oldest summary.
   //--------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_summaries.size() == 0) begin
            $error("result word with no summary pending: count %0d up %h down %h",
                   rsp_chan.value_count, rsp_chan.up_average, rsp_chan.down_average);
            mismatch_count++;
         end else begin
            oldest_summary = expected_summaries.pop_front();
            if (rsp_chan.value_count !== oldest_summary.value_count) begin
               $error("value_count: expected %0d, got %0d",
                      oldest_summary.value_count, rsp_chan.value_count);
               mismatch_count++;
            end
            if (rsp_chan.up_average !== oldest_summary.up_average) begin
               $error("up_average: expected %h, got %h",
                      oldest_summary.up_average, rsp_chan.up_average);
               mismatch_count++;
            end
            if (rsp_chan.down_average !== oldest_summary.down_average) begin
               $error("down_average: expected %h, got %h",
                      oldest_summary.down_average, rsp_chan.down_average);
               mismatch_count++;
            end
         end
      end
   end

   //--------------------------------------------------------------------------
   // Tests
   //--------------------------------------------------------------------------

   // Short hand-picked sequences: lone sample, signed extremes, all flat,
   // leading flats into either slope, flats between and after runs.
   task automatic test_run_shapes();
      // lone sample: zero averages
      seq_words = '{32'sd7};
      send_queued();
      // full signed swing up then down
      seq_words = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000};
      send_queued();
      // flat throughout: zero averages
      seq_words = '{32'sd5, 32'sd5, 32'sd5};
      send_queued();
      // leading flats handed to a rising run
      seq_words = '{32'sd0, 32'sd0, 32'sd1, 32'sd2};
      send_queued();
      // leading flat handed to a falling run
      seq_words = '{32'sd3, 32'sd3, 32'sd1};
      send_queued();
      // flats inside and after runs of both kinds
      seq_words = '{32'sd1, 32'sd2, 32'sd2, 32'sd1, 32'sd1, 32'sd0};
      send_queued();
      seq_words = '{32'sd9, 32'sd8, 32'sd8, 32'sd9, 32'sd9};
      send_queued();
   endtask

   // Hold the result side off while several sequences arrive, so the output
   // register fills and the next last word has to wait at the input.
   task automatic test_output_backpressure();
      send_gaps_on = 1'b0;
      hold_request = HOLD_CYCLES;
      for (int s = 0; s < 5; s++) begin
         seq_words = '{$urandom, $urandom, $urandom};
         send_queued();
      end
      send_gaps_on = 1'b1;
   endtask

   // Random sequences of random shape until the word budget is spent.
   task automatic test_random_sequences(input int word_budget);
      int                 sent;
      int                 len;
      int                 pick;
      walk_kind_type      walk;
      logic signed [31:0] level;
      logic signed [31:0] edge_values[4];
      edge_values = '{32'h8000_0000, 32'h7FFF_FFFF, 32'sd0, -32'sd1};
      sent = 0;
      while (sent < word_budget) begin
         // toggle idling per sequence so some stretches run without gaps
         send_gaps_on = ($urandom_range(0, 3) != 0);
         take_gaps_on = ($urandom_range(0, 3) != 0);
         len  = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 16);
         pick = $urandom_range(0, 3);
         walk = (pick < 2) ? WALK_SMALL : ((pick == 2) ? WALK_FULL : WALK_EDGES);
         level = $urandom;
         for (int k = 0; k < len; k++) begin
            case (walk)
               WALK_SMALL: level = level + (int'($urandom_range(0, 4)) - 2);
               WALK_FULL:  level = $urandom;
               default:    level = edge_values[$urandom_range(0, 3)];
            endcase
            seq_words.push_back(level);
         end
         send_queued();
         sent += len;
      end
      send_gaps_on = 1'b1;
      take_gaps_on = 1'b1;
   endtask

   //--------------------------------------------------------------------------
   // Main sequence
   //--------------------------------------------------------------------------
   initial begin
      clear_runs();
      reset           <= 1'b1;
      req_chan.valid  <= 1'b0;
      req_chan.sample <= '0;
      req_chan.last   <= 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_run_shapes();
      test_output_backpressure();
      test_random_sequences(500);

      // drop valid, drain every owed summary, then let the block settle
      @(posedge clock);
      req_chan.valid <= 1'b0;
      while (expected_summaries.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
